[src/ver_pkg.sv]
// ----------------------------------------------------------------------------
// ver_pkg
// Shared types, constants and tables for the vertex rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package ver_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_W     = 16;
    localparam int TRIG_W      = 16;
    localparam int PROD_W      = COORD_WIDTH + TRIG_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int TH_W        = 20;
    localparam int CX_W        = 33;
    localparam int ADDR_W      = 4;

    localparam logic [1:0] REG_ANGLE_FIRST  = 2'd0;
    localparam logic [1:0] REG_ANGLE_SECOND = 2'd1;
    localparam logic [1:0] REG_ANGLE_THIRD  = 2'd2;

    localparam logic signed [ANGLE_W-1:0] ANGLE_FIRST_RST  = -16'sd410;
    localparam logic signed [ANGLE_W-1:0] ANGLE_SECOND_RST = 16'sd1229;
    localparam logic signed [ANGLE_W-1:0] ANGLE_THIRD_RST  = 16'sd819;

    localparam logic signed [16:0]     INV_PI_Q16  = 17'sd20861;
    localparam logic signed [TH_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [TH_W-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 33'sd652032875;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 16'sd16384;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic signed [COORD_WIDTH-1:0] vertex_z;
    } t_vertex;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic signed [COORD_WIDTH-1:0] rotated_z;
    } t_rotated;

    typedef struct packed {
        logic                     valid;
        logic [1:0]               idx;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_trig_res;

    typedef enum logic [2:0] {
        COR_IDLE,
        COR_MUL,
        COR_FOLD,
        COR_ITER,
        COR_DONE
    } t_cor_state;

    function automatic logic signed [TH_W-1:0] atan_q16(input logic [3:0] i);
        logic signed [TH_W-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/ver_cordic.sv]
// ----------------------------------------------------------------------------
// ver_cordic
// Iterative sine/cosine unit: scale by 1/pi, fold quadrant, 16 CORDIC steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ver_cordic
    import ver_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_launch,
    input  wire logic [1:0]                i_idx,
    input  wire logic signed [ANGLE_W-1:0] i_angle,
    output logic                           o_idle,
    output t_trig_res                      o_res
);

    t_cor_state r_state, n_state;
    logic [1:0]              r_idx;
    logic signed [31:0]      r_prod;
    logic signed [TH_W-1:0]  r_theta;
    logic signed [CX_W-1:0]  r_x, r_y;
    logic [3:0]              r_cnt;
    logic                    r_neg_cos;

    logic                    rnd_neg;
    logic [31:0]             rnd_mag;
    logic [31:0]             rnd_q;
    logic signed [TH_W-1:0]  theta_q;
    logic signed [CX_W-1:0]  dx, dy;
    logic signed [TH_W-1:0]  at;
    logic                    xn, yn;
    logic [CX_W-1:0]         xm, ym;
    logic [CX_W-1:0]         xq, yq;
    logic signed [17:0]      xr, yr, xs;
    logic signed [TRIG_W-1:0] cos_c, sin_c;

    // Round the scaled angle to Q.16, halves away from zero.
    always_comb begin
        rnd_neg = r_prod[31];
        rnd_mag = rnd_neg ? 32'(-r_prod) : 32'(r_prod);
        rnd_q   = (rnd_mag + 32'd2048) >> 12;
        theta_q = rnd_neg ? -TH_W'(signed'(rnd_q[TH_W-1:0]))
                          : TH_W'(signed'(rnd_q[TH_W-1:0]));
    end

    always_comb begin
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        at = atan_q16(r_cnt);
    end

    // Final rounding to Q1.14, cosine sign, clamp.
    always_comb begin
        xn = r_x[CX_W-1];
        yn = r_y[CX_W-1];
        xm = xn ? CX_W'(-r_x) : CX_W'(r_x);
        ym = yn ? CX_W'(-r_y) : CX_W'(r_y);
        xq = (xm + CX_W'(32768)) >> 16;
        yq = (ym + CX_W'(32768)) >> 16;
        xr = xn ? -signed'(xq[17:0]) : signed'(xq[17:0]);
        yr = yn ? -signed'(yq[17:0]) : signed'(yq[17:0]);
        xs = r_neg_cos ? -xr : xr;
        if (xs > 18'sd16384)       cos_c = TRIG_ONE;
        else if (xs < -18'sd16384) cos_c = -TRIG_ONE;
        else                       cos_c = xs[TRIG_W-1:0];
        if (yr > 18'sd16384)       sin_c = TRIG_ONE;
        else if (yr < -18'sd16384) sin_c = -TRIG_ONE;
        else                       sin_c = yr[TRIG_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            COR_IDLE: if (i_launch) n_state = COR_MUL;
            COR_MUL:  n_state = COR_FOLD;
            COR_FOLD: n_state = COR_ITER;
            COR_ITER: if (r_cnt == 4'd15) n_state = COR_DONE;
            COR_DONE: n_state = COR_IDLE;
            default:  n_state = COR_IDLE;
        endcase
    end

    always_comb begin
        o_idle      = (r_state == COR_IDLE);
        o_res.valid = (r_state == COR_DONE);
        o_res.idx   = r_idx;
        o_res.cos_v = cos_c;
        o_res.sin_v = sin_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= COR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            COR_IDLE: begin
                r_idx  <= i_idx;
                r_prod <= 32'(i_angle) * 32'(INV_PI_Q16);
            end
            COR_MUL: begin
                r_theta <= theta_q;
            end
            COR_FOLD: begin
                r_x   <= CORDIC_GAIN;
                r_y   <= '0;
                r_cnt <= '0;
                if (r_theta > HALF_PI_Q16) begin
                    r_theta   <= PI_Q16 - r_theta;
                    r_neg_cos <= 1'b1;
                end else if (r_theta < -HALF_PI_Q16) begin
                    r_theta   <= -PI_Q16 - r_theta;
                    r_neg_cos <= 1'b1;
                end else begin
                    r_neg_cos <= 1'b0;
                end
            end
            COR_ITER: begin
                r_cnt <= r_cnt + 4'd1;
                if (!r_theta[TH_W-1]) begin
                    r_x     <= r_x - dx;
                    r_y     <= r_y + dy;
                    r_theta <= r_theta - at;
                end else begin
                    r_x     <= r_x + dx;
                    r_y     <= r_y - dy;
                    r_theta <= r_theta + at;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[src/ver_rot_stage.sv]
// ----------------------------------------------------------------------------
// ver_rot_stage
// One plane rotation: multiply, then sum, round and saturate; one passes.
// ----------------------------------------------------------------------------
`default_nettype none

module ver_rot_stage
    import ver_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [COORD_WIDTH-1:0] i_a,
    input  wire logic signed [COORD_WIDTH-1:0] i_b,
    input  wire logic signed [COORD_WIDTH-1:0] i_p,
    input  wire logic signed [TRIG_W-1:0]      i_cos,
    input  wire logic signed [TRIG_W-1:0]      i_sin,
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_c0,
    output logic signed [COORD_WIDTH-1:0]      o_c1,
    output logic signed [COORD_WIDTH-1:0]      o_p
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (COORD_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic                          r_v1, r_v2;
    logic signed [PROD_W-1:0]      r_ca, r_sb, r_sa, r_cb;
    logic signed [COORD_WIDTH-1:0] r_p1, r_c0, r_c1, r_p2;

    function automatic logic signed [COORD_WIDTH-1:0] rnd_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic               neg;
        logic [ACC_W-1:0]   mag;
        logic [ACC_W-1:0]   q;
        logic signed [ACC_W-1:0] r;
        neg = acc[ACC_W-1];
        mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
        q   = (mag + ACC_W'(2 ** 13)) >> 14;
        r   = neg ? -signed'(q) : signed'(q);
        if (r > SAT_HI)      return SAT_HI[COORD_WIDTH-1:0];
        else if (r < SAT_LO) return SAT_LO[COORD_WIDTH-1:0];
        else                 return r[COORD_WIDTH-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: products.
    always_ff @(posedge i_clk) begin
        r_ca <= PROD_W'(i_cos) * PROD_W'(i_a);
        r_sb <= PROD_W'(i_sin) * PROD_W'(i_b);
        r_sa <= PROD_W'(i_sin) * PROD_W'(i_a);
        r_cb <= PROD_W'(i_cos) * PROD_W'(i_b);
        r_p1 <= i_p;
    end

    // Stage two: sums to Q.8.
    always_ff @(posedge i_clk) begin
        r_c0 <= rnd_sat(ACC_W'(r_ca) - ACC_W'(r_sb));
        r_c1 <= rnd_sat(ACC_W'(r_sa) + ACC_W'(r_cb));
        r_p2 <= r_p1;
    end

    assign o_valid = r_v2;
    assign o_c0    = r_c0;
    assign o_c1    = r_c1;
    assign o_p     = r_p2;

endmodule

`default_nettype wire

[src/vertex_euler_rotation.sv]
// ----------------------------------------------------------------------------
// vertex_euler_rotation
// Rotates a Q8.8 vertex about z, x and y by three configured angles.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while busy is low.
// The receiver cannot stall: every result appears for exactly one cycle.
// busy is high while the CORDIC unit refreshes the sine/cosine cache; each
// written angle goes through launch and multiply, round, fold, 16 steps, finish.
// After reset all three angles are recomputed while busy is held high.
`default_nettype none

module vertex_euler_rotation
    import ver_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_vertex           i_vertex,
    output logic                   o_valid,
    output t_rotated               o_rotated,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // Angle registers and the trig cache (cos/sin per angle).
    logic signed [ANGLE_W-1:0] r_ang [3];
    logic signed [TRIG_W-1:0]  r_cos [3];
    logic signed [TRIG_W-1:0]  r_sin [3];
    logic [2:0]                r_pending;

    logic       wr_en;
    logic [1:0] wr_idx;
    logic       cor_idle;
    logic       launch;
    logic [1:0] launch_idx;
    t_trig_res  cor_res;

    logic                          s1_v, s2_v, s3_v;
    logic signed [COORD_WIDTH-1:0] s1_x, s1_y, s1_z;
    logic signed [COORD_WIDTH-1:0] s2_y, s2_z, s2_x;
    logic signed [COORD_WIDTH-1:0] s3_z, s3_x, s3_y;
    logic                          r_out_v;
    t_rotated                      r_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[3:2];

    always_comb begin
        case (paddr[3:2])
            REG_ANGLE_FIRST:  prdata = 32'(signed'(r_ang[0]));
            REG_ANGLE_SECOND: prdata = 32'(signed'(r_ang[1]));
            REG_ANGLE_THIRD:  prdata = 32'(signed'(r_ang[2]));
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang[0] <= ANGLE_FIRST_RST;
            r_ang[1] <= ANGLE_SECOND_RST;
            r_ang[2] <= ANGLE_THIRD_RST;
        end else if (wr_en) begin
            case (wr_idx)
                REG_ANGLE_FIRST:  r_ang[0] <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_SECOND: r_ang[1] <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_THIRD:  r_ang[2] <= pwdata[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pick the lowest angle waiting for a refresh.
    always_comb begin
        launch_idx = REG_ANGLE_FIRST;
        if (r_pending[0])      launch_idx = REG_ANGLE_FIRST;
        else if (r_pending[1]) launch_idx = REG_ANGLE_SECOND;
        else                   launch_idx = REG_ANGLE_THIRD;
        launch = cor_idle && (r_pending != 3'b000);
    end

    // Clear a pending bit at launch; a write re-arms it so a stale result
    // is simply recomputed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'b111;
        end else begin
            r_pending <= (r_pending & ~(launch ? (3'b001 << launch_idx) : 3'b000))
                       | ((wr_en && wr_idx != 2'd3) ? (3'b001 << wr_idx) : 3'b000);
        end
    end

    ver_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_launch(launch),
        .i_idx   (launch_idx),
        .i_angle (r_ang[launch_idx]),
        .o_idle  (cor_idle),
        .o_res   (cor_res)
    );

    // Capture finished trig values into the cache.
    always_ff @(posedge i_clk) begin
        if (cor_res.valid) begin
            r_cos[cor_res.idx] <= cor_res.cos_v;
            r_sin[cor_res.idx] <= cor_res.sin_v;
        end
    end

    assign busy = (r_pending != 3'b000) || !cor_idle;

    // About z with the third angle: (x, y) rotate, z passes.
    ver_rot_stage u_rot_z (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(start && !busy),
        .i_a    (i_vertex.vertex_x),
        .i_b    (i_vertex.vertex_y),
        .i_p    (i_vertex.vertex_z),
        .i_cos  (r_cos[2]),
        .i_sin  (r_sin[2]),
        .o_valid(s1_v),
        .o_c0   (s1_x),
        .o_c1   (s1_y),
        .o_p    (s1_z)
    );

    // About x with the second angle: (y, z) rotate, x passes.
    ver_rot_stage u_rot_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s1_v),
        .i_a    (s1_y),
        .i_b    (s1_z),
        .i_p    (s1_x),
        .i_cos  (r_cos[1]),
        .i_sin  (r_sin[1]),
        .o_valid(s2_v),
        .o_c0   (s2_y),
        .o_c1   (s2_z),
        .o_p    (s2_x)
    );

    // About y with the first angle: (z, x) rotate, y passes.
    ver_rot_stage u_rot_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s2_v),
        .i_a    (s2_z),
        .i_b    (s2_x),
        .i_p    (s2_y),
        .i_cos  (r_cos[0]),
        .i_sin  (r_sin[0]),
        .o_valid(s3_v),
        .o_c0   (s3_z),
        .o_c1   (s3_x),
        .o_p    (s3_y)
    );

    // Output register: hold each word for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.rotated_x <= s3_x;
        r_out.rotated_y <= s3_y;
        r_out.rotated_z <= s3_z;
    end

    assign o_valid   = r_out_v;
    assign o_rotated = r_out;

endmodule

`default_nettype wire

[bench/vertex_euler_rotation_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_euler_rotation_chk
// Watches the vertex and APB channels, predicts each rotated vertex from a
// private copy of the angles and trig cache, and counts mismatches.
// ----------------------------------------------------------------------------
module vertex_euler_rotation_chk
    import ver_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire t_vertex           i_vertex,
    input  wire logic              o_valid,
    input  wire t_rotated          o_rotated,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    input  wire logic              pready,
    output int                     o_fail_count,
    output int                     o_pending
);

    logic signed [15:0] angle_q [3];
    longint             trig_q [6];
    t_rotated           rotated_due [$];

    function automatic longint rnd_shift(longint v, int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -(((-v) + half) >>> s);
    endfunction

    function automatic longint sat_q88(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint tab [16];
        tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    // CORDIC sine/cosine of angle/pi, written out from the fixed-point recipe
    task automatic calc_sincos(input logic signed [15:0] ang,
                               output longint c, output longint s);
        longint theta, x, y, dx, dy;
        bit     flip;
        theta = rnd_shift(longint'(ang) * 20861, 12);
        flip = 0;
        x = 652032875;
        y = 0;
        if (theta > 102944) begin
            theta = 205887 - theta;
            flip = 1;
        end else if (theta < -102944) begin
            theta = -205887 - theta;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (theta >= 0) begin
                x -= dx; y += dy; theta -= atan_step(i);
            end else begin
                x += dx; y -= dy; theta += atan_step(i);
            end
        end
        x = rnd_shift(x, 16);
        y = rnd_shift(y, 16);
        if (flip) x = -x;
        c = clamp_one(x);
        s = clamp_one(y);
    endtask

    task automatic rebuild_trig();
        for (int k = 0; k < 3; k++) calc_sincos(angle_q[k], trig_q[2*k], trig_q[2*k+1]);
    endtask

    function automatic longint mac3(longint a, longint b, longint c,
                                    longint p, longint q, longint r);
        return sat_q88(rnd_shift(a * p + b * q + c * r, 14));
    endfunction

    function automatic t_rotated rotate_vertex(t_vertex v);
        longint x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3;
        longint c1, s1, c2, s2, c3, s3;
        t_rotated r;
        c1 = trig_q[0]; s1 = trig_q[1];
        c2 = trig_q[2]; s2 = trig_q[3];
        c3 = trig_q[4]; s3 = trig_q[5];
        x0 = v.vertex_x; y0 = v.vertex_y; z0 = v.vertex_z;
        x1 = mac3(c3, -s3, 0, x0, y0, z0);
        y1 = mac3(s3, c3, 0, x0, y0, z0);
        z1 = mac3(0, 0, 16384, x0, y0, z0);
        x2 = mac3(16384, 0, 0, x1, y1, z1);
        y2 = mac3(0, c2, -s2, x1, y1, z1);
        z2 = mac3(0, s2, c2, x1, y1, z1);
        x3 = mac3(c1, 0, s1, x2, y2, z2);
        y3 = mac3(0, 16384, 0, x2, y2, z2);
        z3 = mac3(-s1, 0, c1, x2, y2, z2);
        r.rotated_x = x3[15:0];
        r.rotated_y = y3[15:0];
        r.rotated_z = z3[15:0];
        return r;
    endfunction

    assign o_pending = rotated_due.size();

    always @(posedge i_clk) begin
        t_rotated want;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            angle_q[0] = ANGLE_FIRST_RST;
            angle_q[1] = ANGLE_SECOND_RST;
            angle_q[2] = ANGLE_THIRD_RST;
            rebuild_trig();
            rotated_due.delete();
            o_fail_count <= 0;
        end else begin
            if (o_valid) begin
                if (rotated_due.size() == 0) begin
                    $error("rotated word with nothing expected");
                    errs++;
                end else begin
                    want = rotated_due.pop_front();
                    if (o_rotated.rotated_x !== want.rotated_x) begin
                        $error("rotated_x exp %0d got %0d", want.rotated_x,
                               o_rotated.rotated_x);
                        errs++;
                    end
                    if (o_rotated.rotated_y !== want.rotated_y) begin
                        $error("rotated_y exp %0d got %0d", want.rotated_y,
                               o_rotated.rotated_y);
                        errs++;
                    end
                    if (o_rotated.rotated_z !== want.rotated_z) begin
                        $error("rotated_z exp %0d got %0d", want.rotated_z,
                               o_rotated.rotated_z);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            if (start && !busy) rotated_due.push_back(rotate_vertex(i_vertex));
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ANGLE_FIRST:  angle_q[0] = pwdata[15:0];
                    REG_ANGLE_SECOND: angle_q[1] = pwdata[15:0];
                    REG_ANGLE_THIRD:  angle_q[2] = pwdata[15:0];
                    default: ;
                endcase
                rebuild_trig();
            end
        end
    end

endmodule

[bench/vertex_euler_rotation_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_euler_rotation_tb
// Drives vertices and angle writes into the rotation block; the checker
// beside it predicts and compares every rotated word.
// ----------------------------------------------------------------------------
module vertex_euler_rotation_tb;
    import ver_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_vertex           i_vertex;
    logic              o_valid;
    t_rotated          o_rotated;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                cycle_count;

    localparam int CYCLE_LIMIT = 400000;

    vertex_euler_rotation dut (
        .i_clk, .i_rst_n, .start, .busy, .i_vertex, .o_valid, .o_rotated,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    vertex_euler_rotation_chk chk (
        .i_clk, .i_rst_n, .start, .busy, .i_vertex, .o_valid, .o_rotated,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Pick a coordinate: extremes often, sometimes small values near zero, otherwise full-range noise.
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold the presented word until an edge at which busy was low.
    task automatic wait_accept();
        bit took;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    // Present one vertex word and hold it until the block takes it.
    task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_vertex <= '{vertex_x: x, vertex_y: y, vertex_z: z};
        wait_accept();
    endtask

    // Drop start, drain outstanding words, then let the pipeline settle.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // APB write: setup cycle then access cycle; pready is always high.
    task automatic write_angle(input logic [1:0] idx, input logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom_range(0, 65535)), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_angles(input logic [15:0] a0, input logic [15:0] a1,
                              input logic [15:0] a2);
        wait_idle();
        write_angle(REG_ANGLE_FIRST, a0);
        write_angle(REG_ANGLE_SECOND, a1);
        write_angle(REG_ANGLE_THIRD, a2);
    endtask

    initial begin
        logic [15:0] edges [4];
        edges = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        cycle_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_vertex = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: coordinate extremes under the reset angles.
        foreach (edges[a])
            foreach (edges[b]) send_vertex(edges[a], edges[b], edges[(a + b) % 4]);
        send_vertex(16'h0100, 16'h0000, 16'h0000);
        send_vertex(16'h0000, 16'h0100, 16'h0000);
        send_vertex(16'h0000, 16'h0000, 16'h0100);

        // Angle extremes: full range folds both quadrants; zero is identity.
        set_angles(16'h7fff, 16'h8000, 16'h0000);
        foreach (edges[a]) send_vertex(edges[a], edges[3 - a], edges[a]);
        // Unmapped register: write is ignored.
        wait_idle();
        write_angle(2'd3, 16'h1234);

        // Random phases with fresh angles.
        for (int ph = 0; ph < 15; ph++) begin
            case (ph % 3)
                0: set_angles(16'($urandom), 16'($urandom), 16'($urandom));
                1: set_angles(16'($urandom_range(0, 12868)) - 16'd6434,
                              16'($urandom_range(0, 12868)) - 16'd6434,
                              16'($urandom_range(0, 12868)) - 16'd6434);
                default: set_angles(16'h8000, 16'h7fff, 16'($urandom));
            endcase
            for (int n = 0; n < 72; n++) begin
                send_vertex(pick_coord(), pick_coord(), pick_coord());
                // Back-to-back bursts with no gaps.
                if (n % 20 == 0)
                    repeat (4) begin
                        start <= 1'b1;
                        i_vertex <= '{vertex_x: pick_coord(), vertex_y: pick_coord(),
                                      vertex_z: pick_coord()};
                        wait_accept();
                    end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
